FILE: rtl/core/sdpcm_pkg.sv
// sdpcm_pkg: word types, register indexes and step tables for the DPCM audio decoder.
// Used by sdpcm_step, sdpcm_obuf and sol_dpcm_audio_decoder. No dependencies.
package sdpcm_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_EIGHT_BIT_MODE        = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_DIRECT_NEGATIVE_INDEX = t_cfg_idx'(1);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first_of_stream;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_run;
    } t_out_word;

    // decoded samples for one code byte
    typedef struct packed {
        logic               two;
        logic signed [15:0] s0;
        logic signed [15:0] s1;
    } t_step_res;

    localparam logic signed [15:0] START_WIDE   = 16'sd0;
    localparam logic signed [15:0] START_NARROW = 16'sd128;

    localparam logic [14:0] WIDE_STEPS [0:127] = '{
        15'h0000, 15'h0008, 15'h0010, 15'h0020, 15'h0030, 15'h0040, 15'h0050, 15'h0060,
        15'h0070, 15'h0080, 15'h0090, 15'h00A0, 15'h00B0, 15'h00C0, 15'h00D0, 15'h00E0,
        15'h00F0, 15'h0100, 15'h0110, 15'h0120, 15'h0130, 15'h0140, 15'h0150, 15'h0160,
        15'h0170, 15'h0180, 15'h0190, 15'h01A0, 15'h01B0, 15'h01C0, 15'h01D0, 15'h01E0,
        15'h01F0, 15'h0200, 15'h0208, 15'h0210, 15'h0218, 15'h0220, 15'h0228, 15'h0230,
        15'h0238, 15'h0240, 15'h0248, 15'h0250, 15'h0258, 15'h0260, 15'h0268, 15'h0270,
        15'h0278, 15'h0280, 15'h0288, 15'h0290, 15'h0298, 15'h02A0, 15'h02A8, 15'h02B0,
        15'h02B8, 15'h02C0, 15'h02C8, 15'h02D0, 15'h02D8, 15'h02E0, 15'h02E8, 15'h02F0,
        15'h02F8, 15'h0300, 15'h0308, 15'h0310, 15'h0318, 15'h0320, 15'h0328, 15'h0330,
        15'h0338, 15'h0340, 15'h0348, 15'h0350, 15'h0358, 15'h0360, 15'h0368, 15'h0370,
        15'h0378, 15'h0380, 15'h0388, 15'h0390, 15'h0398, 15'h03A0, 15'h03A8, 15'h03B0,
        15'h03B8, 15'h03C0, 15'h03C8, 15'h03D0, 15'h03D8, 15'h03E0, 15'h03E8, 15'h03F0,
        15'h03F8, 15'h0400, 15'h0440, 15'h0480, 15'h04C0, 15'h0500, 15'h0540, 15'h0580,
        15'h05C0, 15'h0600, 15'h0640, 15'h0680, 15'h06C0, 15'h0700, 15'h0740, 15'h0780,
        15'h07C0, 15'h0800, 15'h0900, 15'h0A00, 15'h0B00, 15'h0C00, 15'h0D00, 15'h0E00,
        15'h0F00, 15'h1000, 15'h1400, 15'h1800, 15'h1C00, 15'h2000, 15'h3000, 15'h4000
    };

    localparam logic [4:0] NARROW_STEPS [0:7] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

FILE: rtl/core/sdpcm_step.sv
// sdpcm_step: decodes one code byte against the predictor, both modes, with clamping.
// Depends on sdpcm_pkg.
module sdpcm_step (
    input  logic signed [15:0]   i_pred,
    input  sdpcm_pkg::t_in_word  i_word,
    input  logic                 i_eight,
    input  logic                 i_direct,
    output sdpcm_pkg::t_step_res o_res,
    output logic signed [15:0]   o_pred_next
);

    function automatic logic [7:0] nib_dec(input logic signed [15:0] p,
                                           input logic [3:0] nib,
                                           input logic direct);
        logic [2:0]         idx;
        logic [4:0]         mag;
        logic signed [17:0] sum;
        logic [7:0]         res;
        idx = nib[2:0];
        if (nib[3]) begin
            mag = direct ? sdpcm_pkg::NARROW_STEPS[idx] : sdpcm_pkg::NARROW_STEPS[~idx];
            sum = 18'(p) - $signed({13'b0, mag});
        end else begin
            mag = sdpcm_pkg::NARROW_STEPS[idx];
            sum = 18'(p) + $signed({13'b0, mag});
        end
        if (sum < 18'sd0) begin
            res = 8'd0;
        end else if (sum > 18'sd255) begin
            res = 8'd255;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

    logic signed [15:0] base16;
    logic signed [15:0] base8;
    logic [14:0]        step16;
    logic signed [17:0] sum16;
    logic signed [15:0] s16;
    logic [7:0]         n0;
    logic [7:0]         n1;

    always_comb begin
        base16 = i_word.first_of_stream ? sdpcm_pkg::START_WIDE : i_pred;
        step16 = sdpcm_pkg::WIDE_STEPS[i_word.code_byte[6:0]];
        if (i_word.code_byte[7]) begin
            sum16 = 18'(base16) - $signed({3'b0, step16});
        end else begin
            sum16 = 18'(base16) + $signed({3'b0, step16});
        end
        if (sum16 < -18'sd32768) begin
            s16 = -16'sd32768;
        end else if (sum16 > 18'sd32767) begin
            s16 = 16'sd32767;
        end else begin
            s16 = sum16[15:0];
        end

        base8 = i_word.first_of_stream ? sdpcm_pkg::START_NARROW : i_pred;
        n0 = nib_dec(base8, i_word.code_byte[7:4], i_direct);
        n1 = nib_dec($signed({8'b0, n0}), i_word.code_byte[3:0], i_direct);

        o_res.two   = i_eight;
        o_res.s0    = i_eight ? $signed({8'b0, n0}) : s16;
        o_res.s1    = $signed({8'b0, n1});
        o_pred_next = i_eight ? $signed({8'b0, n1}) : s16;
    end

endmodule

FILE: rtl/core/sdpcm_obuf.sv
// sdpcm_obuf: result buffer holding the samples of one byte, sent one word at a time.
// Depends on sdpcm_pkg.
module sdpcm_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  sdpcm_pkg::t_step_res i_res,
    output logic                 o_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sdpcm_pkg::t_out_word o_out_word
);

    logic                 r_valid, n_valid;
    logic                 r_idx, n_idx;
    sdpcm_pkg::t_step_res r_res, n_res;
    logic                 fire;
    logic                 last;

    always_comb begin
        fire    = r_valid && !i_out_stall;
        last    = !r_res.two || r_idx;
        o_ready = !r_valid || (fire && last);
        n_valid = r_valid;
        n_idx   = r_idx;
        n_res   = r_res;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 1'b0;
            n_res   = i_res;
        end else if (fire) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = 1'b1;
            end
        end
        o_out_valid            = r_valid;
        o_out_word.sample      = r_idx ? r_res.s1 : r_res.s0;
        o_out_word.last_of_run = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_res <= n_res;
    end

endmodule

FILE: rtl/core/sol_dpcm_audio_decoder.sv
// sol_dpcm_audio_decoder: top level of the DPCM audio decoder.
// Depends on sdpcm_pkg, sdpcm_step and sdpcm_obuf.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_stall    | t_in_word (code, start)
//  out     | out       | o_out_valid / i_out_stall  | t_out_word (sample, last)
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The input register, decode in one pass, then the result buffer.
// 16-bit mode: one byte per cycle unless the output stalls. 8-bit mode:
// two output words per byte; the buffer takes a new byte as the second leaves.
// Reset clears control, predictor (0) and registers; no clearing pass.
// A stall on the output backs up into o_in_stall once both stages hold words.
module sol_dpcm_audio_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdpcm_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdpcm_pkg::t_out_word  o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  sdpcm_pkg::t_cfg_idx   i_cfg_index,
    input  sdpcm_pkg::t_cfg_data  i_cfg_data
);

    logic                 r_in_valid;
    sdpcm_pkg::t_in_word  r_in_word;
    logic signed [15:0]   r_pred;
    logic                 r_eight;
    logic                 r_direct;
    logic                 ob_ready;
    logic                 consume;
    logic                 accept;
    sdpcm_pkg::t_step_res step_res;
    logic signed [15:0]   pred_next;

    assign consume     = r_in_valid && ob_ready;
    assign o_in_stall  = r_in_valid && !consume;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    sdpcm_step u_step (
        .i_pred      (r_pred),
        .i_word      (r_in_word),
        .i_eight     (r_eight),
        .i_direct    (r_direct),
        .o_res       (step_res),
        .o_pred_next (pred_next)
    );

    sdpcm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (consume),
        .i_res       (step_res),
        .o_ready     (ob_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pred     <= '0;
            r_eight    <= 1'b0;
            r_direct   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_pred <= pred_next;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sdpcm_pkg::CFG_EIGHT_BIT_MODE:        r_eight  <= i_cfg_data[0];
                    sdpcm_pkg::CFG_DIRECT_NEGATIVE_INDEX: r_direct <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    // stall only with a word waiting that the buffer cannot take
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && !ob_ready))
        else $error("input stalled without a pending word");

    // 8-bit mode keeps the predictor in 0..255
    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_eight) |=> (r_pred[15:8] == 8'd0))
        else $error("predictor out of 8-bit range");

    // final word taken with nothing loaded empties the buffer
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.last_of_run && !consume)
        |=> !o_out_valid)
        else $error("result buffer did not drain");

endmodule

FILE: bench/dpcm_sample_checker.sv
`timescale 1ns / 100ps
// dpcm_sample_checker: watches the code, sample and register channels of the DPCM
// audio decoder, predicts every sample word and compares. Depends on sdpcm_pkg.
module dpcm_sample_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  sdpcm_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  sdpcm_pkg::t_out_word i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  sdpcm_pkg::t_cfg_idx  i_cfg_index,
    input  sdpcm_pkg::t_cfg_data i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    int                   level = 0;
    logic                 eight_bit = 1'b0;
    logic                 direct_neg = 1'b0;
    int                   err_count = 0;
    sdpcm_pkg::t_out_word expected;
    sdpcm_pkg::t_out_word pending_samples[$];

    function automatic int wide_step(input logic [6:0] idx);
        int i;
        i = idx;
        if (i == 0) return 0;
        if (i == 1) return 8;
        if (i <= 32) return (i - 1) * 'h10;
        if (i <= 97) return 'h200 + (i - 33) * 'h8;
        if (i <= 113) return 'h400 + (i - 97) * 'h40;
        if (i <= 121) return 'h800 + (i - 113) * 'h100;
        if (i <= 125) return 'h1000 + (i - 121) * 'h400;
        if (i == 126) return 'h3000;
        return 'h4000;
    endfunction

    function automatic int narrow_step(input logic [2:0] idx);
        case (idx)
            3'd0: return 0;
            3'd1: return 1;
            3'd2: return 2;
            3'd3: return 3;
            3'd4: return 6;
            3'd5: return 10;
            3'd6: return 15;
            default: return 21;
        endcase
    endfunction

    function automatic void push_sample(input logic last);
        sdpcm_pkg::t_out_word w;
        w.sample      = level[15:0];
        w.last_of_run = last;
        pending_samples.push_back(w);
    endfunction

    function automatic void step_nibble(input logic [3:0] nib);
        logic [2:0] idx;
        idx = (nib[3] && !direct_neg) ? 3'd7 - nib[2:0] : nib[2:0];
        if (nib[3])
            level -= narrow_step(idx);
        else
            level += narrow_step(idx);
        if (level < 0)
            level = 0;
        else if (level > 255)
            level = 255;
    endfunction

    function automatic void decode_code_byte(input sdpcm_pkg::t_in_word w);
        if (!eight_bit) begin
            if (w.first_of_stream)
                level = 0;
            if (w.code_byte[7])
                level -= wide_step(w.code_byte[6:0]);
            else
                level += wide_step(w.code_byte[6:0]);
            if (level < -32768)
                level = -32768;
            else if (level > 32767)
                level = 32767;
            push_sample(1'b1);
        end else begin
            if (w.first_of_stream)
                level = 128;
            step_nibble(w.code_byte[7:4]);
            push_sample(1'b0);
            step_nibble(w.code_byte[3:0]);
            push_sample(1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level      = 0;
            eight_bit  = 1'b0;
            direct_neg = 1'b0;
            pending_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sdpcm_pkg::CFG_EIGHT_BIT_MODE:        eight_bit  = i_cfg_data[0];
                    sdpcm_pkg::CFG_DIRECT_NEGATIVE_INDEX: direct_neg = i_cfg_data[0];
                    default: ;
                endcase
            end
            // output first: a word leaving now cannot stem from a byte entering now
            if (i_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    $error("sample: expected none, actual %0d", i_out_word.sample);
                    err_count++;
                end else begin
                    expected = pending_samples.pop_front();
                    if (i_out_word.sample !== expected.sample) begin
                        $error("sample: expected %0d, actual %0d",
                               expected.sample, i_out_word.sample);
                        err_count++;
                    end
                    if (i_out_word.last_of_run !== expected.last_of_run) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               expected.last_of_run, i_out_word.last_of_run);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_code_byte(i_in_word);
        end
        o_pending <= pending_samples.size();
        o_errors  <= err_count;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: clock, reset, code byte stimulus, register writes and verdict for the DPCM
// audio decoder. Depends on sdpcm_pkg, sol_dpcm_audio_decoder and dpcm_sample_checker.
module tb;

    localparam int CYCLE_LIMIT = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    sdpcm_pkg::t_in_word  in_word = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    sdpcm_pkg::t_cfg_idx  cfg_index = '0;
    sdpcm_pkg::t_cfg_data cfg_data = '0;

    logic                 in_stall;
    logic                 out_valid;
    sdpcm_pkg::t_out_word out_word;
    logic                 cfg_ready;
    int                   pending;
    int                   errors;

    int        cycle_count = 0;
    int        hold_cycles = 0;
    int        burst_left = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    sol_dpcm_audio_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dpcm_sample_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] code, input logic first);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = (tx_calm || burst_left > 0) ? 0 : $urandom_range(0, 11);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= sdpcm_pkg::t_in_word'{code_byte: code, first_of_stream: first};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input sdpcm_pkg::t_cfg_idx idx, input sdpcm_pkg::t_cfg_data val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // upper data bits and a stray index are noise the block must ignore
    task automatic configure(input logic mode, input logic dni);
        write_reg(sdpcm_pkg::CFG_EIGHT_BIT_MODE, {7'($urandom_range(0, 127)), mode});
        write_reg(sdpcm_pkg::CFG_DIRECT_NEGATIVE_INDEX, {7'($urandom_range(0, 127)), dni});
        write_reg(sdpcm_pkg::t_cfg_idx'($urandom_range(2, 15)),
                  sdpcm_pkg::t_cfg_data'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 11))
            0: return 8'h7F;
            1: return 8'hFF;
            2: return 8'h00;
            3: return 8'h80;
            4: return 8'h77;
            5: return 8'h88;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int n;
        forever begin
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end else begin
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                n = rx_calm ? 0 : $urandom_range(0, 11);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        logic mode;
        logic dni;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // 16-bit: top and bottom clamps, zero steps both ways
        configure(1'b0, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h7F, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);

        // 8-bit with reversed index, entered without a start mark
        wait_results();
        configure(1'b1, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h77, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h88, 1'b0);
        send_word(8'h8F, 1'b1);

        wait_results();
        configure(1'b1, 1'b1);
        send_word(8'h8F, 1'b1);
        send_word(8'hF8, 1'b0);

        // back to 16-bit, predictor carried over
        wait_results();
        configure(1'b0, 1'b1);
        send_word(8'h05, 1'b0);
        send_word(8'h8F, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            wait_results();
            mode = (ph == 4) ? 1'($urandom_range(0, 1)) : (ph < 2);
            dni  = (ph == 4) ? 1'($urandom_range(0, 1)) : 1'(ph % 2);
            configure(mode, dni);
            for (int k = 0; k < 80; k++) begin
                if (ph == 1 && k == 30) begin
                    hold_cycles = 160;
                    burst_left  = 40;
                end
                if (ph == 3 && k == 40)
                    wait_results();
                send_word(pick_code(), k == 0 || $urandom_range(0, 24) == 0);
            end
        end

        wait_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
